[design/rmp_pkg.sv]
package rmp_pkg;

    localparam int MAX_ACTIONS = 8;
    localparam int MAX_CARDS   = 64;

    localparam int ACT_W      = $clog2(MAX_ACTIONS);
    localparam int CARD_W     = $clog2(MAX_CARDS);
    localparam int REG_AW     = ACT_W + CARD_W;
    localparam int REG_DEPTH  = MAX_ACTIONS * MAX_CARDS;

    localparam int REGRET_W   = 31;
    localparam int SUM_W      = 34;
    localparam int DELTA_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int STRAT_W    = FRAC_W + 1;

    localparam int ACNT_W     = 4;
    localparam int CCNT_W     = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTION_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CARD_COUNT   = 1'b1;

    localparam logic [ACNT_W-1:0] ACNT_RESET = 4'd2;
    localparam logic [CCNT_W-1:0] CCNT_RESET = 7'd3;

    localparam logic [STRAT_W-1:0] ONE_Q16 = STRAT_W'(1) << FRAC_W;

    // Read and write request from the sequencer to the state memories
    typedef struct packed {
        logic [ACT_W-1:0]    rd_act;
        logic [CARD_W-1:0]   rd_card;
        logic                wr_en;
        logic [ACT_W-1:0]    wr_act;
        logic [CARD_W-1:0]   wr_card;
        logic [REGRET_W-1:0] wr_regret;
        logic [SUM_W-1:0]    wr_sum;
    } t_mem_cmd;

    // floor(65536 / n), with a zero count acting as one
    function automatic logic [STRAT_W-1:0] uniform_share(input logic [ACNT_W-1:0] n);
        logic [STRAT_W-1:0] v;
        begin
            case (n)
                4'd0:    v = 17'd65536;
                4'd1:    v = 17'd65536;
                4'd2:    v = 17'd32768;
                4'd3:    v = 17'd21845;
                4'd4:    v = 17'd16384;
                4'd5:    v = 17'd13107;
                4'd6:    v = 17'd10922;
                4'd7:    v = 17'd9362;
                4'd8:    v = 17'd8192;
                4'd9:    v = 17'd7281;
                4'd10:   v = 17'd6553;
                4'd11:   v = 17'd5957;
                4'd12:   v = 17'd5461;
                4'd13:   v = 17'd5041;
                4'd14:   v = 17'd4681;
                4'd15:   v = 17'd4369;
                default: v = 17'd65536;
            endcase
            return v;
        end
    endfunction

endpackage

[design/rmp_store.sv]
module rmp_store
    import rmp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_mem_cmd            i_cmd,
    output logic [REGRET_W-1:0] o_regret,
    output logic [SUM_W-1:0]    o_sum,
    output logic                o_busy
);

    logic [REGRET_W-1:0] regret_mem [REG_DEPTH];
    logic [SUM_W-1:0]    sum_mem    [MAX_CARDS];

    logic                r_clr_busy;
    logic [REG_AW-1:0]   r_clr_addr;

    logic                reg_we;
    logic [REG_AW-1:0]   reg_waddr;
    logic [REGRET_W-1:0] reg_wdata;
    logic [CARD_W-1:0]   sum_waddr;
    logic [SUM_W-1:0]    sum_wdata;

    // Clearing pass after reset takes the write port over
    always_comb begin
        if (r_clr_busy) begin
            reg_we    = 1'b1;
            reg_waddr = r_clr_addr;
            reg_wdata = '0;
            sum_waddr = r_clr_addr[CARD_W-1:0];
            sum_wdata = '0;
        end else begin
            reg_we    = i_cmd.wr_en;
            reg_waddr = {i_cmd.wr_act, i_cmd.wr_card};
            reg_wdata = i_cmd.wr_regret;
            sum_waddr = i_cmd.wr_card;
            sum_wdata = i_cmd.wr_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == REG_AW'(REG_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (reg_we) begin
            regret_mem[reg_waddr] <= reg_wdata;
        end
        o_regret <= regret_mem[{i_cmd.rd_act, i_cmd.rd_card}];
    end

    always_ff @(posedge i_clk) begin
        if (reg_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        o_sum <= sum_mem[i_cmd.rd_card];
    end

    assign o_busy = r_clr_busy;

endmodule

[design/rmp_div.sv]
module rmp_div
    import rmp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [REGRET_W-1:0] i_num,
    input  logic [SUM_W-1:0]    i_den,
    output logic                o_done,
    output logic [STRAT_W-1:0]  o_quo
);

    localparam int CNT_W = $clog2(FRAC_W + 1);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_sat;
    logic [SUM_W-1:0]   r_rem;
    logic [SUM_W-1:0]   r_den;
    logic [FRAC_W-1:0]  r_quo;

    logic [SUM_W:0]     shifted;
    logic [SUM_W:0]     diff;
    logic               start_sat;

    assign start_sat = {{(SUM_W-REGRET_W){1'b0}}, i_num} >= i_den;
    assign shifted   = {r_rem, 1'b0};
    assign diff      = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= start_sat ? '0 : CNT_W'(FRAC_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Restoring division, one quotient bit a cycle; the remainder stays below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat <= start_sat;
            r_rem <= {{(SUM_W-REGRET_W){1'b0}}, i_num};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy && r_cnt != '0) begin
            if (shifted >= {1'b0, r_den}) begin
                r_rem <= diff[SUM_W-1:0];
                r_quo <= {r_quo[FRAC_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[SUM_W-1:0];
                r_quo <= {r_quo[FRAC_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = r_sat ? ONE_Q16 : {1'b0, r_quo};

endmodule

[design/regret_matching_plus_core.sv]
// Regret-matching-plus table for one decision node.
//
// Input channel (i_valid / o_stall): one element per transfer. i_op 0 updates
// the positive regret of (i_action, i_card) with the Q16.16 value i_regret and
// gives no result; i_op 1 queries the strategy of (i_action, i_card) and gives
// one Q1.16 result on the output channel (o_valid / i_stall).
// Configuration: i_cfg_we with i_cfg_idx 0 writes action_count, 1 card_count;
// write only while the block is idle.
// Sequence: an update reads the memories, then writes back. A query whose card sum
// is non-zero runs the 16-step restoring divider; when the regret reaches the sum
// the divider ends at once. Other queries skip the divider. o_stall stays high
// until an update has written back or a query result is loaded for output.
// The regret and sum memories have registered reads.
// Reset: a clearing pass walks the 512-entry regret memory one entry a cycle;
// o_stall stays high until the pass ends. Config registers return to
// action_count 2, card_count 3.
// A stalled result waits in the output register; the block accepts the next
// element meanwhile and holds a further query result until that register frees.
module regret_matching_plus_core
    import rmp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_op,
    input  logic [ACT_W-1:0]           i_action,
    input  logic [CARD_W-1:0]          i_card,
    input  logic signed [DELTA_W-1:0]  i_regret,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [STRAT_W-1:0]         o_strategy
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MOD   = 6'b000100,
        S_DIV   = 6'b001000,
        S_DONE  = 6'b010000,
        S_WAIT  = 6'b100000
    } t_state;

    t_state                    r_state, n_state;
    logic [ACNT_W-1:0]         r_action_count;
    logic [CCNT_W-1:0]         r_card_count;
    logic                      r_any_seen;
    logic                      r_op;
    logic                      r_ok;
    logic [ACT_W-1:0]          r_action;
    logic [CARD_W-1:0]         r_card;
    logic signed [DELTA_W-1:0] r_regret;
    logic [STRAT_W-1:0]        r_res, n_res;
    logic                      r_o_valid;
    logic [STRAT_W-1:0]        r_o_strategy;

    t_mem_cmd                  mem_cmd;
    logic [REGRET_W-1:0]       rd_regret;
    logic [SUM_W-1:0]          rd_sum;
    logic                      clr_busy;

    logic                      div_start;
    logic                      div_done;
    logic [STRAT_W-1:0]        div_quo;

    logic                      in_xfer;
    logic                      ok_in;
    logic signed [REGRET_W+1:0] acc;
    logic [REGRET_W-1:0]       next_regret;
    logic [SUM_W:0]            sum_add;
    logic [SUM_W-1:0]          next_sum;
    logic                      out_free;

    assign o_stall = (r_state != S_IDLE);
    assign in_xfer = i_valid && !o_stall;
    assign ok_in   = ({1'b0, i_action} < r_action_count) && ({1'b0, i_card} < r_card_count);
    assign out_free = !r_o_valid || !i_stall;

    // Clamp at zero, saturate at the top of the regret range
    assign acc = $signed({2'b00, rd_regret}) + $signed({{(REGRET_W+2-DELTA_W){r_regret[DELTA_W-1]}},
                                                        r_regret});
    always_comb begin
        if (acc[REGRET_W+1]) begin
            next_regret = '0;
        end else if (acc[REGRET_W]) begin
            next_regret = '1;
        end else begin
            next_regret = acc[REGRET_W-1:0];
        end
    end

    assign sum_add = {1'b0, rd_sum} + {{(SUM_W+1-REGRET_W){1'b0}}, next_regret};
    always_comb begin
        if (r_action == '0) begin
            next_sum = {{(SUM_W-REGRET_W){1'b0}}, next_regret};
        end else if (sum_add[SUM_W]) begin
            next_sum = '1;
        end else begin
            next_sum = sum_add[SUM_W-1:0];
        end
    end

    always_comb begin
        mem_cmd.rd_act    = (r_state == S_IDLE) ? i_action : r_action;
        mem_cmd.rd_card   = (r_state == S_IDLE) ? i_card : r_card;
        mem_cmd.wr_en     = (r_state == S_MOD) && !r_op && r_ok;
        mem_cmd.wr_act    = r_action;
        mem_cmd.wr_card   = r_card;
        mem_cmd.wr_regret = next_regret;
        mem_cmd.wr_sum    = next_sum;
    end

    rmp_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (mem_cmd),
        .o_regret (rd_regret),
        .o_sum    (rd_sum),
        .o_busy   (clr_busy)
    );

    assign div_start = (r_state == S_MOD) && r_op && r_ok && r_any_seen && (rd_sum != '0);

    rmp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (rd_regret),
        .i_den   (rd_sum),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        case (r_state)
            S_CLEAR: begin
                if (!clr_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (!r_op) begin
                    n_state = S_IDLE;
                end else if (!r_ok) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end else if (div_start) begin
                    n_state = S_DIV;
                end else begin
                    n_res   = uniform_share(r_action_count);
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_res   = div_quo;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (in_xfer) begin
            r_op     <= i_op;
            r_ok     <= ok_in;
            r_action <= i_action;
            r_card   <= i_card;
            r_regret <= i_regret;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any_seen <= 1'b0;
        end else if (mem_cmd.wr_en) begin
            r_any_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_action_count <= ACNT_RESET;
            r_card_count   <= CCNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACTION_COUNT: r_action_count <= i_cfg_data[ACNT_W-1:0];
                CFG_CARD_COUNT:   r_card_count   <= i_cfg_data[CCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Output register: load a finished result when free or being transferred, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((r_state == S_DONE || r_state == S_WAIT) && out_free) begin
            r_o_valid <= 1'b1;
        end else if (r_o_valid && !i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE || r_state == S_WAIT) && out_free) begin
            r_o_strategy <= r_res;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_strategy = r_o_strategy;

endmodule
